/* hdl/sactc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package sactc_pkg;

   // address and tag geometry
   localparam int ADDR_W     = 32;
   localparam int TAG_W      = 30;
   localparam int RAW_SET_W  = 7;
   localparam int RAW_SETS   = 128;

   // default sizing of the tag store
   localparam int DEF_MAX_SETS = 64;
   localparam int DEF_MAX_WAYS = 8;

   // stream port widths
   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 1;
   localparam int RSP_TDATA_W = 8;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 5;

   localparam logic [CSR_ADDR_W-1:0] CSR_OFFSET_BITS    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_INDEX_BITS     = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_WAYS_IN_USE    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_USE_LRU        = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_ALLOC_MODE     = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_THRU_MODE      = 3'd5;

   // configuration reset values
   localparam logic [4:0] RST_OFFSET_BITS = 5'd2;
   localparam logic [2:0] RST_INDEX_BITS  = 3'd0;
   localparam logic [3:0] RST_WAYS_IN_USE = 4'd8;
   localparam logic       RST_USE_LRU     = 1'b1;
   localparam logic       RST_WRITE_ALLOC = 1'b1;
   localparam logic       RST_WRITE_THRU  = 1'b0;

   // smallest offset honored
   localparam logic [4:0] MIN_OFFSET_BITS = 5'd2;

   // access kinds
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_STORE = 1'b1;

   // sequencer control toward the way scan unit
   typedef struct packed {
      logic clear;
      logic step;
   } scan_ctrl_type;

endpackage
`default_nettype wire

/* hdl/sactc_tag_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module sactc_tag_ram #(
   parameter int DEPTH  = 64,
   parameter int AW     = 6,
   parameter int WIDTH  = 8
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

/* hdl/sactc_way_scan.sv */
`timescale 1ns / 1ps
`default_nettype none
module sactc_way_scan #(
   parameter int WAY_W  = 3,
   parameter int RANK_W = 3
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire sactc_pkg::scan_ctrl_type     ctrl,
   input  wire logic [WAY_W-1:0]             way,
   input  wire logic                         way_valid,
   input  wire logic [sactc_pkg::TAG_W-1:0]  way_tag,
   input  wire logic [RANK_W-1:0]            way_rank,
   input  wire logic [sactc_pkg::TAG_W-1:0]  look_tag,
   output logic                              hit,
   output logic      [WAY_W-1:0]             hit_way,
   output logic                              free,
   output logic      [WAY_W-1:0]             free_way,
   output logic      [WAY_W-1:0]             max_way
);
   import sactc_pkg::*;

   logic              hit_ff, hit_in;
   logic [WAY_W-1:0]  hit_way_ff, hit_way_in;
   logic              free_ff, free_in;
   logic [WAY_W-1:0]  free_way_ff, free_way_in;
   logic [RANK_W-1:0] max_rank_ff, max_rank_in;
   logic [WAY_W-1:0]  max_way_ff, max_way_in;
   logic              tag_eq;

   // shared tag comparator
   assign tag_eq = (way_tag == look_tag);

   // accumulate first match, first free way and oldest way
   always_comb begin
      hit_in      = hit_ff;
      hit_way_in  = hit_way_ff;
      free_in     = free_ff;
      free_way_in = free_way_ff;
      max_rank_in = max_rank_ff;
      max_way_in  = max_way_ff;
      if (ctrl.clear) begin
         hit_in      = 1'b0;
         free_in     = 1'b0;
         max_rank_in = '0;
         max_way_in  = '0;
      end else if (ctrl.step) begin
         if (!hit_ff && way_valid && tag_eq) begin
            hit_in     = 1'b1;
            hit_way_in = way;
         end
         if (!free_ff && !way_valid) begin
            free_in     = 1'b1;
            free_way_in = way;
         end
         if (way_rank > max_rank_ff) begin
            max_rank_in = way_rank;
            max_way_in  = way;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else begin
         hit_ff  <= hit_in;
         free_ff <= free_in;
      end
      hit_way_ff  <= hit_way_in;
      free_way_ff <= free_way_in;
      max_rank_ff <= max_rank_in;
      max_way_ff  <= max_way_in;
   end

   assign hit      = hit_ff;
   assign hit_way  = hit_way_ff;
   assign free     = free_ff;
   assign free_way = free_way_ff;
   assign max_way  = max_way_ff;

endmodule
`default_nettype wire

/* hdl/set_assoc_cache_tag_controller_core.sv */
// order: a transaction reads the set row, passes each way in use in turn through the shared tag comparator,
// then writes the row back; the result is valid the cycle after
// a new transaction is accepted only in the idle state, after the previous one has written its row back
// reset: synchronous; configuration returns to its defaults and a clearing pass writes every
// set row to empty, during which req_tready stays low
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_cache_tag_controller_core #(
   parameter int MAX_SETS = sactc_pkg::DEF_MAX_SETS,
   parameter int MAX_WAYS = sactc_pkg::DEF_MAX_WAYS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // req_tdata: address[31:0]
   input  wire logic [sactc_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // req_tuser: command[0]
   input  wire logic [sactc_pkg::REQ_TUSER_W-1:0]   req_tuser,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // rsp_tdata: hit[0], write_back[1], filled[2], zero[7:3]
   output logic      [sactc_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   input  wire logic                                csr_we,
   input  wire logic [sactc_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [sactc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import sactc_pkg::*;

   localparam int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int RANK_W   = WAY_W;
   localparam int CAP_W    = $clog2(MAX_WAYS + 1);
   localparam int CMP_W    = (CAP_W > 4) ? CAP_W : 4;
   localparam int TAGS_W   = MAX_WAYS * TAG_W;
   localparam int VALID_LO = TAGS_W;
   localparam int DIRTY_LO = TAGS_W + MAX_WAYS;
   localparam int RANK_LO  = TAGS_W + 2 * MAX_WAYS;
   localparam int ROW_W    = RANK_LO + MAX_WAYS * RANK_W;

   localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);
   localparam logic [SET_W-1:0]  SET_LAST = SET_W'(MAX_SETS - 1);

   localparam logic [1:0] S_CLEAR  = 2'd0;
   localparam logic [1:0] S_IDLE   = 2'd1;
   localparam logic [1:0] S_SCAN   = 2'd2;
   localparam logic [1:0] S_UPDATE = 2'd3;

   // configuration registers
   logic [4:0] offset_ff;
   logic [2:0] index_ff;
   logic [3:0] ways_ff;
   logic       lru_ff;
   logic       walloc_ff;
   logic       wthru_ff;

   // sequencer and transaction registers
   logic [1:0]       state_ff, state_in;
   logic [SET_W-1:0] clr_ff;
   logic [WAY_W-1:0] way_ff;
   logic             cmd_ff;
   logic [TAG_W-1:0] tag_ff;
   logic [SET_W-1:0] set_ff;
   logic             rsp_valid_ff;
   logic [2:0]       rsp_data_ff;

   logic              accept;
   logic              upd_fire;
   logic              scan_last;
   logic [4:0]        off_eff;
   logic [ADDR_W-1:0] addr_shift;
   logic [ADDR_W-1:0] tag_shift;
   logic [5:0]        tag_amt;
   logic [RAW_SET_W-1:0] set_mask;
   logic [RAW_SET_W-1:0] set_raw;
   logic [SET_W-1:0]  set_calc;
   logic [SET_W-1:0]  set_lut [RAW_SETS];
   logic [CMP_W-1:0]  ways_ext;
   logic [CAP_W-1:0]  cap;

   logic             ram_we;
   logic [SET_W-1:0] ram_waddr;
   logic [ROW_W-1:0] ram_wdata;
   logic [ROW_W-1:0] row_rd;
   logic [ROW_W-1:0] row_new;

   scan_ctrl_type    scan_ctrl;
   logic             scan_hit, scan_free;
   logic [WAY_W-1:0] scan_hit_way, scan_free_way, scan_max_way;
   logic             upd_hit, upd_alloc, upd_wb;
   logic [WAY_W-1:0] victim;
   logic [RANK_W-1:0] hit_rank;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= RST_OFFSET_BITS;
         index_ff  <= RST_INDEX_BITS;
         ways_ff   <= RST_WAYS_IN_USE;
         lru_ff    <= RST_USE_LRU;
         walloc_ff <= RST_WRITE_ALLOC;
         wthru_ff  <= RST_WRITE_THRU;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_OFFSET_BITS:    offset_ff <= csr_wdata[4:0];
            CSR_INDEX_BITS:     index_ff  <= csr_wdata[2:0];
            CSR_WAYS_IN_USE:    ways_ff   <= csr_wdata[3:0];
            CSR_USE_LRU:        lru_ff    <= csr_wdata[0];
            CSR_ALLOC_MODE:     walloc_ff <= csr_wdata[0];
            CSR_THRU_MODE:      wthru_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // set index wraps modulo the number of sets
   for (genvar i = 0; i < RAW_SETS; i++) begin : g_set_lut
      assign set_lut[i] = SET_W'(i % MAX_SETS);
   end

   // address split into set and tag
   always_comb begin
      off_eff    = (offset_ff < MIN_OFFSET_BITS) ? MIN_OFFSET_BITS : offset_ff;
      addr_shift = req_tdata[ADDR_W-1:0] >> off_eff;
      set_mask   = ~({RAW_SET_W{1'b1}} << index_ff);
      set_raw    = addr_shift[RAW_SET_W-1:0] & set_mask;
      set_calc   = set_lut[set_raw];
      tag_amt    = 6'(off_eff) + 6'(index_ff);
      tag_shift  = req_tdata[ADDR_W-1:0] >> tag_amt;
   end

   // clamp the way count
   always_comb begin
      ways_ext = CMP_W'(ways_ff);
      if (ways_ext == '0) begin
         cap = CAP_W'(1);
      end else if (ways_ext > CMP_W'(MAX_WAYS)) begin
         cap = CAP_W'(MAX_WAYS);
      end else begin
         cap = ways_ext[CAP_W-1:0];
      end
   end

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign scan_last  = (CAP_W'(way_ff) + CAP_W'(1)) == cap;
   assign upd_fire   = (state_ff == S_UPDATE) && (!rsp_valid_ff || rsp_tready);

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR:  if (clr_ff == SET_LAST) state_in = S_IDLE;
         S_IDLE:   if (accept) state_in = S_SCAN;
         S_SCAN:   if (scan_last) state_in = S_UPDATE;
         S_UPDATE: if (upd_fire) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         way_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) begin
            clr_ff <= clr_ff + SET_W'(1);
         end
         if (accept) begin
            way_ff <= '0;
         end else if (state_ff == S_SCAN && !scan_last) begin
            way_ff <= way_ff + WAY_W'(1);
         end
      end
   end

   // transaction capture
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_tuser[0];
         tag_ff <= tag_shift[TAG_W-1:0];
         set_ff <= set_calc;
      end
   end

   // set row store
   assign ram_we    = (state_ff == S_CLEAR) || upd_fire;
   assign ram_waddr = (state_ff == S_CLEAR) ? clr_ff : set_ff;
   assign ram_wdata = (state_ff == S_CLEAR) ? '0 : row_new;

   sactc_tag_ram #(
      .DEPTH (MAX_SETS),
      .AW    (SET_W),
      .WIDTH (ROW_W)
   ) u_tag_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (accept),
      .raddr (set_calc),
      .rdata (row_rd)
   );

   // one way per cycle through the shared comparator
   assign scan_ctrl.clear = accept;
   assign scan_ctrl.step  = (state_ff == S_SCAN);

   sactc_way_scan #(
      .WAY_W  (WAY_W),
      .RANK_W (RANK_W)
   ) u_way_scan (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (scan_ctrl),
      .way       (way_ff),
      .way_valid (row_rd[VALID_LO + int'(way_ff)]),
      .way_tag   (row_rd[int'(way_ff) * TAG_W +: TAG_W]),
      .way_rank  (row_rd[RANK_LO + int'(way_ff) * RANK_W +: RANK_W]),
      .look_tag  (tag_ff),
      .hit       (scan_hit),
      .hit_way   (scan_hit_way),
      .free      (scan_free),
      .free_way  (scan_free_way),
      .max_way   (scan_max_way)
   );

   // outcome of the lookup
   assign upd_hit   = scan_hit;
   assign upd_alloc = !scan_hit && (cmd_ff == CMD_LOAD || walloc_ff);
   assign victim    = scan_free ? scan_free_way : scan_max_way;
   assign hit_rank  = row_rd[RANK_LO + int'(scan_hit_way) * RANK_W +: RANK_W];
   assign upd_wb    = upd_alloc && !scan_free && row_rd[DIRTY_LO + int'(victim)] && !wthru_ff;

   // new row: recency, dirty and fill per way
   always_comb begin
      row_new = row_rd;
      for (int w = 0; w < MAX_WAYS; w++) begin
         logic             v;
         logic             in_cap;
         logic [RANK_W-1:0] r;
         v      = row_rd[VALID_LO + w];
         in_cap = CAP_W'(w) < cap;
         r      = row_rd[RANK_LO + w * RANK_W +: RANK_W];
         if (upd_hit) begin
            if (WAY_W'(w) == scan_hit_way) begin
               if (cmd_ff == CMD_STORE) begin
                  row_new[DIRTY_LO + w] = 1'b1;
               end
               if (lru_ff) begin
                  r = '0;
               end
            end else if (lru_ff && in_cap && v && r < hit_rank && r != RANK_MAX) begin
               r = r + RANK_W'(1);
            end
         end else if (upd_alloc) begin
            if (WAY_W'(w) == victim) begin
               row_new[VALID_LO + w]          = 1'b1;
               row_new[w * TAG_W +: TAG_W]    = tag_ff;
               row_new[DIRTY_LO + w]          = cmd_ff;
               r = '0;
            end else if (in_cap && v && r != RANK_MAX) begin
               r = r + RANK_W'(1);
            end
         end
         row_new[RANK_LO + w * RANK_W +: RANK_W] = r;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (upd_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (upd_fire) begin
         rsp_data_ff <= {upd_alloc, upd_wb, upd_hit};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - 3){1'b0}}, rsp_data_ff};

   // an accepted transaction always starts the way scan
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_SCAN))
      else $error("accepted transaction did not start the scan");

   // a result only appears after a row update
   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_UPDATE))
      else $error("result raised outside the update step");

   // a hit never allocates a line
   a_hit_no_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE) |-> !(upd_hit && upd_alloc))
      else $error("hit and fill at once");

   // a blocked update holds until the result register frees
   a_update_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE && rsp_valid_ff && !rsp_tready) |=> (state_ff == S_UPDATE))
      else $error("update left while result still pending");

endmodule
`default_nettype wire
